// ----- sv/lru_cache_timestamp_top_macros.svh -----
// Assertion macros for the cache checker.
`ifndef LRU_CACHE_TIMESTAMP_TOP_MACROS_SVH
`define LRU_CACHE_TIMESTAMP_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/lct_pkg.sv -----
// Shared types and constants for the timestamp LRU cache.
package lct_pkg;

	localparam int LCT_SLOTS     = 8;
	localparam int LCT_TAG_BITS  = 32;
	localparam int LCT_DATA_BITS = 32;
	localparam int LCT_KEY_W     = 32;
	localparam int LCT_DIN_W     = 32;
	localparam int LCT_STAMP_W   = 64;
	localparam int LCT_CFG_W     = 4;
	localparam int LCT_SLOT_W    = 3;
	localparam int LCT_OCC_W     = 4;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_PROBE  = 2'd2,
		KIND_CLEAR  = 2'd3
	} lct_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_RESP
	} lct_state_t;

	// Controls for the slot memories; all fields share one address.
	typedef struct packed {
		logic rd_en;
		logic tag_data_we;
		logic stamp_we;
	} lct_mem_ctl_t;

endpackage

// ----- sv/lct_store.sv -----
// Slot memories: tag, payload and stamp arrays with registered reads.
module lct_store #(
	parameter int SLOTS     = lct_pkg::LCT_SLOTS,
	parameter int TAG_BITS  = lct_pkg::LCT_TAG_BITS,
	parameter int DATA_BITS = lct_pkg::LCT_DATA_BITS,
	parameter int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                              clk,
	input  lct_pkg::lct_mem_ctl_t             mem_ctl,
	input  logic [IDX_W-1:0]                  addr,
	input  logic [TAG_BITS-1:0]               wr_tag,
	input  logic [DATA_BITS-1:0]              wr_data,
	input  logic [lct_pkg::LCT_STAMP_W-1:0]   wr_stamp,
	output logic [TAG_BITS-1:0]               rd_tag,
	output logic [DATA_BITS-1:0]              rd_data,
	output logic [lct_pkg::LCT_STAMP_W-1:0]   rd_stamp
);
	import lct_pkg::*;

	logic [TAG_BITS-1:0]    tag_mem   [SLOTS];
	logic [DATA_BITS-1:0]   data_mem  [SLOTS];
	logic [LCT_STAMP_W-1:0] stamp_mem [SLOTS];

	logic [TAG_BITS-1:0]    rd_tag_q;
	logic [DATA_BITS-1:0]   rd_data_q;
	logic [LCT_STAMP_W-1:0] rd_stamp_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.tag_data_we) begin
			tag_mem[addr]  <= wr_tag;
			data_mem[addr] <= wr_data;
		end
		if (mem_ctl.stamp_we) begin
			stamp_mem[addr] <= wr_stamp;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rd_tag_q   <= tag_mem[addr];
			rd_data_q  <= data_mem[addr];
			rd_stamp_q <= stamp_mem[addr];
		end
	end

	assign rd_tag   = rd_tag_q;
	assign rd_data  = rd_data_q;
	assign rd_stamp = rd_stamp_q;

endmodule

// ----- sv/lct_ctrl.sv -----
// Sequencer: slot scan, replacement choice, valid bits, access clock and result register.
module lct_ctrl #(
	parameter int SLOTS     = lct_pkg::LCT_SLOTS,
	parameter int TAG_BITS  = lct_pkg::LCT_TAG_BITS,
	parameter int DATA_BITS = lct_pkg::LCT_DATA_BITS,
	parameter int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lct_pkg::LCT_CFG_W-1:0]     cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [lct_pkg::LCT_KEY_W-1:0]     key,
	input  logic [lct_pkg::LCT_DIN_W-1:0]     data_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [lct_pkg::LCT_DIN_W-1:0]     data_out,
	output logic                              evicted,
	output logic [lct_pkg::LCT_SLOT_W-1:0]    slot_index,
	output logic [lct_pkg::LCT_OCC_W-1:0]     occupied_count,
	output lct_pkg::lct_mem_ctl_t             mem_ctl,
	output logic [IDX_W-1:0]                  mem_addr,
	output logic [TAG_BITS-1:0]               wr_tag,
	output logic [DATA_BITS-1:0]              wr_data,
	output logic [lct_pkg::LCT_STAMP_W-1:0]   wr_stamp,
	input  logic [TAG_BITS-1:0]               rd_tag,
	input  logic [DATA_BITS-1:0]              rd_data,
	input  logic [lct_pkg::LCT_STAMP_W-1:0]   rd_stamp
);
	import lct_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1);

	lct_state_t              state_q, state_d;
	lct_kind_t               kind_q;
	logic [TAG_BITS-1:0]     key_q;
	logic [DATA_BITS-1:0]    din_q;
	logic [CNT_W-1:0]        cap_q;
	logic [CNT_W-1:0]        cap_d;
	logic [SLOTS-1:0]        valid_q;
	logic [LCT_STAMP_W-1:0]  clock_q;
	logic [LCT_STAMP_W-1:0]  clock_inc;

	logic [IDX_W-1:0]        pos_s1;
	logic                    found_q;
	logic [IDX_W-1:0]        match_q;
	logic                    have_empty_q;
	logic [IDX_W-1:0]        empty_q;
	logic                    have_old_q;
	logic [IDX_W-1:0]        old_q;
	logic [LCT_STAMP_W-1:0]  old_stamp_q;

	logic                    r_hit_q;
	logic                    r_evict_q;
	logic [IDX_W-1:0]        r_slot_q;

	logic                    out_valid_q;
	logic                    hit_q;
	logic [LCT_DIN_W-1:0]    data_out_q;
	logic                    evicted_q;
	logic [LCT_SLOT_W-1:0]   slot_index_q;
	logic [LCT_OCC_W-1:0]    occupied_q;

	logic                    accept;
	logic                    scan_last;
	logic                    out_free;
	logic [IDX_W-1:0]        victim;
	logic                    is_lookup;
	logic                    is_insert;

	assign accept    = in_valid && in_ready;
	assign scan_last = (CNT_W'(pos_s1) + CNT_W'(1)) == cap_q;
	assign out_free  = !out_valid_q || out_ready;
	assign victim    = have_empty_q ? empty_q : old_q;
	assign is_lookup = kind_q == KIND_LOOKUP;
	assign is_insert = kind_q == KIND_INSERT;
	assign clock_inc = clock_q + LCT_STAMP_W'(1);

	assign wr_tag   = key_q;
	assign wr_data  = din_q;
	assign wr_stamp = clock_inc;

	// Clamp written capacity into 1..SLOTS.
	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_d = CNT_W'(1);
		end else if (int'(cfg_wr_data) > SLOTS) begin
			cap_d = CNT_W'(SLOTS);
		end else begin
			cap_d = CNT_W'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_ctl  = '0;
		mem_addr = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (lct_kind_t'(kind) == KIND_CLEAR) begin
						state_d = ST_RESP;
					end else begin
						mem_ctl.rd_en = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_RESOLVE;
				end else begin
					mem_ctl.rd_en = 1'b1;
					mem_addr      = pos_s1 + IDX_W'(1);
				end
			end
			ST_RESOLVE: begin
				mem_addr = found_q ? match_q : victim;
				if (found_q) begin
					mem_ctl.stamp_we = is_lookup || is_insert;
					mem_ctl.rd_en    = is_lookup;
				end else begin
					mem_ctl.stamp_we    = is_insert;
					mem_ctl.tag_data_we = is_insert;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Capacity, valid bits and access clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(SLOTS);
			valid_q <= '0;
			clock_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cap_d;
				for (int i = 0; i < SLOTS; i++) begin
					if (i >= int'(cap_d)) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
			if (accept && lct_kind_t'(kind) == KIND_CLEAR) begin
				valid_q <= '0;
			end
			if (state_q == ST_RESOLVE) begin
				if (mem_ctl.stamp_we) begin
					clock_q <= clock_inc;
				end
				if (mem_ctl.tag_data_we) begin
					valid_q[victim] <= 1'b1;
				end
			end
		end
	end

	// Request capture and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= lct_kind_t'(kind);
			key_q        <= TAG_BITS'(key);
			din_q        <= DATA_BITS'(data_in);
			pos_s1       <= '0;
			found_q      <= 1'b0;
			have_empty_q <= 1'b0;
			have_old_q   <= 1'b0;
			r_hit_q      <= 1'b0;
			r_evict_q    <= 1'b0;
			r_slot_q     <= '0;
		end else if (state_q == ST_SCAN) begin
			if (valid_q[pos_s1]) begin
				if (!found_q && rd_tag == key_q) begin
					found_q <= 1'b1;
					match_q <= pos_s1;
				end
				if (!have_old_q || rd_stamp < old_stamp_q) begin
					have_old_q  <= 1'b1;
					old_q       <= pos_s1;
					old_stamp_q <= rd_stamp;
				end
			end else if (!have_empty_q) begin
				have_empty_q <= 1'b1;
				empty_q      <= pos_s1;
			end
			if (!scan_last) begin
				pos_s1 <= pos_s1 + IDX_W'(1);
			end
		end else if (state_q == ST_RESOLVE) begin
			r_hit_q   <= found_q;
			r_evict_q <= !found_q && is_insert && !have_empty_q;
			if (found_q) begin
				r_slot_q <= match_q;
			end else if (is_insert) begin
				r_slot_q <= victim;
			end else begin
				r_slot_q <= '0;
			end
		end
	end

	// Result register; loads in the response state once the previous result has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			hit_q        <= r_hit_q;
			data_out_q   <= (is_lookup && r_hit_q) ? LCT_DIN_W'(rd_data) : '0;
			evicted_q    <= r_evict_q;
			slot_index_q <= LCT_SLOT_W'(r_slot_q);
			occupied_q   <= LCT_OCC_W'($countones(valid_q));
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign data_out       = data_out_q;
	assign evicted        = evicted_q;
	assign slot_index     = slot_index_q;
	assign occupied_count = occupied_q;

endmodule

// ----- sv/lru_cache_timestamp_top.sv -----
// Fully associative cache with timestamp LRU replacement: top level.
// Flow: a lookup, insert or probe scans the active capacity slot by slot, is then resolved,
//   and its result is registered from the response state; a clear goes straight to response.
// One request at a time, paced by the scan that reads one slot a cycle through the single
//   memory read port; no new request is taken until the result is loaded into the output register.
// Reset: valid bits and access clock cleared, capacity set to SLOTS; no clearing pass.
module lru_cache_timestamp_top #(
	parameter int SLOTS     = lct_pkg::LCT_SLOTS,
	parameter int TAG_BITS  = lct_pkg::LCT_TAG_BITS,
	parameter int DATA_BITS = lct_pkg::LCT_DATA_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lct_pkg::LCT_CFG_W-1:0]     cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [lct_pkg::LCT_KEY_W-1:0]     key,
	input  logic [lct_pkg::LCT_DIN_W-1:0]     data_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [lct_pkg::LCT_DIN_W-1:0]     data_out,
	output logic                              evicted,
	output logic [lct_pkg::LCT_SLOT_W-1:0]    slot_index,
	output logic [lct_pkg::LCT_OCC_W-1:0]     occupied_count
);
	import lct_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	lct_mem_ctl_t           mem_ctl;
	logic [IDX_W-1:0]       mem_addr;
	logic [TAG_BITS-1:0]    wr_tag;
	logic [DATA_BITS-1:0]   wr_data;
	logic [LCT_STAMP_W-1:0] wr_stamp;
	logic [TAG_BITS-1:0]    rd_tag;
	logic [DATA_BITS-1:0]   rd_data;
	logic [LCT_STAMP_W-1:0] rd_stamp;

	lct_ctrl #(
		.SLOTS     (SLOTS),
		.TAG_BITS  (TAG_BITS),
		.DATA_BITS (DATA_BITS),
		.IDX_W     (IDX_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.key            (key),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.data_out       (data_out),
		.evicted        (evicted),
		.slot_index     (slot_index),
		.occupied_count (occupied_count),
		.mem_ctl        (mem_ctl),
		.mem_addr       (mem_addr),
		.wr_tag         (wr_tag),
		.wr_data        (wr_data),
		.wr_stamp       (wr_stamp),
		.rd_tag         (rd_tag),
		.rd_data        (rd_data),
		.rd_stamp       (rd_stamp)
	);

	lct_store #(
		.SLOTS     (SLOTS),
		.TAG_BITS  (TAG_BITS),
		.DATA_BITS (DATA_BITS),
		.IDX_W     (IDX_W)
	) u_store (
		.clk      (clk),
		.mem_ctl  (mem_ctl),
		.addr     (mem_addr),
		.wr_tag   (wr_tag),
		.wr_data  (wr_data),
		.wr_stamp (wr_stamp),
		.rd_tag   (rd_tag),
		.rd_data  (rd_data),
		.rd_stamp (rd_stamp)
	);

endmodule

// ----- sv/lct_checker.sv -----
// Port-level checker for the cache top level, with its bind.
`include "lru_cache_timestamp_top_macros.svh"

module lct_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              hit,
	input logic [lct_pkg::LCT_DIN_W-1:0]     data_out,
	input logic                              evicted,
	input logic [lct_pkg::LCT_SLOT_W-1:0]    slot_index,
	input logic [lct_pkg::LCT_OCC_W-1:0]     occupied_count
);
	import lct_pkg::*;

	// A stalled result holds its valid, hit, data and slot index.
	`LCT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(data_out) && $stable(slot_index), "stalled result changed")

	// Payload only comes back on a hit.
	`LCT_ASSERT_IMP(a_dout_miss, out_valid && !hit, data_out == '0, "data_out nonzero without hit")

	// An eviction happens only on a miss into a non-empty cache.
	`LCT_ASSERT_IMP(a_evict_miss, out_valid && evicted, !hit && occupied_count != '0, "eviction on hit or empty cache")

	// One request at a time: busy right after a request is taken.
	`LCT_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind lru_cache_timestamp_top lct_checker u_lct_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the timestamp LRU cache: shadow cache, request driver, reply check.
module tb_top;
	import lct_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 135;

	typedef struct {
		logic                 hit;
		logic [LCT_DIN_W-1:0] data;
		logic                 evicted;
		logic [LCT_SLOT_W-1:0] slot;
		logic [LCT_OCC_W-1:0] occupied;
	} reply_t;

	// Shadow copy of the cache contents; predicts the reply of every accepted request.
	class lru_shadow;
		bit                   live [LCT_SLOTS];
		bit [LCT_KEY_W-1:0]   tag_of [LCT_SLOTS];
		bit [LCT_DIN_W-1:0]   data_of [LCT_SLOTS];
		bit [LCT_STAMP_W-1:0] stamp_of [LCT_SLOTS];
		bit [LCT_STAMP_W-1:0] access_clock;
		int unsigned          cap = LCT_SLOTS;
		reply_t               expected_replies [$];
		int unsigned          errors, requests, hits, evictions, clears;

		function void load_cap(logic [LCT_CFG_W-1:0] value);
			cap = (value == 0) ? 1 : (value > LCT_SLOTS) ? LCT_SLOTS : value;
			for (int i = cap; i < LCT_SLOTS; i++)
				live[i] = 1'b0;
		endfunction

		function void note_request(lct_kind_t k, bit [LCT_KEY_W-1:0] tag,
				bit [LCT_DIN_W-1:0] din);
			reply_t      r;
			bit          found, have_free, have_old;
			int unsigned hit_slot, free_slot, oldest, target;
			r = '{default: '0};
			found = 0;
			have_free = 0;
			have_old = 0;
			hit_slot = 0;
			free_slot = 0;
			oldest = 0;
			requests++;
			if (k == KIND_CLEAR) begin
				foreach (live[i])
					live[i] = 1'b0;
				clears++;
			end else begin
				// one pass: first match, first free slot, oldest stamp
				for (int i = 0; i < cap; i++) begin
					if (live[i]) begin
						if (!found && tag_of[i] == tag) begin
							found = 1;
							hit_slot = i;
						end
						if (!have_old || stamp_of[i] < stamp_of[oldest]) begin
							have_old = 1;
							oldest = i;
						end
					end else if (!have_free) begin
						have_free = 1;
						free_slot = i;
					end
				end
				if (found) begin
					r.hit = 1'b1;
					r.slot = LCT_SLOT_W'(hit_slot);
					hits++;
					if (k == KIND_LOOKUP) begin
						r.data = data_of[hit_slot];
						access_clock++;
						stamp_of[hit_slot] = access_clock;
					end else if (k == KIND_INSERT) begin
						// restamp only, old data stays
						access_clock++;
						stamp_of[hit_slot] = access_clock;
					end
				end else if (k == KIND_INSERT) begin
					target = have_free ? free_slot : oldest;
					if (!have_free) begin
						r.evicted = 1'b1;
						evictions++;
					end
					tag_of[target] = tag;
					data_of[target] = din;
					live[target] = 1'b1;
					access_clock++;
					stamp_of[target] = access_clock;
					r.slot = LCT_SLOT_W'(target);
				end
			end
			foreach (live[i])
				r.occupied += LCT_OCC_W'(live[i]);
			expected_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with no request outstanding: hit=%0b data=%0h evicted=%0b slot=%0d occupied=%0d",
					$time, got.hit, got.data, got.evicted, got.slot, got.occupied);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			compare_field("hit", 32'(want.hit), 32'(got.hit));
			compare_field("data_out", want.data, got.data);
			compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
			compare_field("slot_index", 32'(want.slot), 32'(got.slot));
			compare_field("occupied_count", 32'(want.occupied), 32'(got.occupied));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [LCT_CFG_W-1:0]  cfg_wr_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            kind;
	logic [LCT_KEY_W-1:0]  key;
	logic [LCT_DIN_W-1:0]  data_in;
	logic                  out_valid;
	logic                  out_ready;
	logic                  hit;
	logic [LCT_DIN_W-1:0]  data_out;
	logic                  evicted;
	logic [LCT_SLOT_W-1:0] slot_index;
	logic [LCT_OCC_W-1:0]  occupied_count;

	lru_shadow   book;
	int          in_idle_max;
	int          out_idle_max;
	int unsigned capacity_writes;

	lru_cache_timestamp_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.key            (key),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.data_out       (data_out),
		.evicted        (evicted),
		.slot_index     (slot_index),
		.occupied_count (occupied_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_request(lct_kind_t k, logic [LCT_KEY_W-1:0] tag,
			logic [LCT_DIN_W-1:0] din);
		int gap;
		gap = $urandom_range(0, in_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		key <= tag;
		data_in <= din;
		do @(posedge clk); while (!in_ready);
		book.note_request(k, tag, din);
	endtask

	task automatic drain_replies();
		int     stall;
		reply_t got;
		forever begin
			stall = $urandom_range(0, out_idle_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.hit = hit;
			got.data = data_out;
			got.evicted = evicted;
			got.slot = slot_index;
			got.occupied = occupied_count;
			book.check_reply(got);
		end
	endtask

	// Drop valid, let every reply drain, then give the block time to return to idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (book.expected_replies.size() != 0)
			@(posedge clk);
		repeat (LCT_SLOTS + 4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [LCT_CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		book.load_cap(value);
		capacity_writes++;
	endtask

	// Mostly keys from a small pool so hits, restamps and evictions are common.
	task automatic run_random_phase(int count);
		logic [LCT_KEY_W-1:0] pool [12];
		int                   pool_size;
		int                   pick;
		lct_kind_t            k;
		logic [LCT_KEY_W-1:0] tag;
		pool_size = book.cap + $urandom_range(1, 4);
		foreach (pool[i])
			pool[i] = $urandom;
		if ($urandom_range(0, 2) == 0)
			pool[0] = '0;
		if ($urandom_range(0, 2) == 0)
			pool[1] = '1;
		in_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
		out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			k = (pick < 40) ? KIND_LOOKUP : (pick < 75) ? KIND_INSERT :
				(pick < 97) ? KIND_PROBE : KIND_CLEAR;
			tag = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
			send_request(k, tag, $urandom);
		end
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, quiet);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [LCT_CFG_W-1:0] cap_plan [12];
		cap_plan = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd2, 4'd11, 4'd7, 4'd3, 4'd6, 4'd5, 4'd8};
		book = new;
		capacity_writes = 0;
		in_idle_max = 0;
		out_idle_max = 15;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_LOOKUP;
		key <= '0;
		data_in <= '0;
		out_ready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_replies();
		join_none

		// directed: empty misses, fill, restamp, evictions, clear
		send_request(KIND_LOOKUP, '0, '1);
		send_request(KIND_PROBE, '1, '1);
		send_request(KIND_INSERT, '0, '1);
		send_request(KIND_INSERT, '1, '0);
		for (int i = 1; i <= 6; i++)
			send_request(KIND_INSERT, 32'(i) * 32'h1111_1111, $urandom);
		send_request(KIND_INSERT, '0, 32'h5a5a_5a5a);
		send_request(KIND_LOOKUP, '1, '1);
		send_request(KIND_PROBE, '0, '1);
		send_request(KIND_INSERT, 32'hdead_beef, 32'h1234_5678);
		send_request(KIND_INSERT, 32'hcafe_f00d, '1);
		send_request(KIND_LOOKUP, 32'h1111_1111, '0);
		send_request(KIND_LOOKUP, 32'hdead_beef, '0);
		send_request(KIND_CLEAR, '1, '1);
		send_request(KIND_LOOKUP, '0, '1);
		send_request(KIND_INSERT, 32'h8000_0001, 32'h7fff_fffe);

		// each phase starts with a new capacity written while the cache still holds entries
		for (int p = 0; p < 14; p++) begin
			wait_idle();
			write_capacity((p < 12) ? cap_plan[p] : LCT_CFG_W'($urandom_range(0, 15)));
			run_random_phase(PHASE_ITEMS);
		end
		wait_idle();

		$display("Covered %0d requests: %0d hits, %0d evictions, %0d clears, %0d capacity writes",
			book.requests, book.hits, book.evictions, book.clears, capacity_writes);
		if (book.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+sv
sv/lct_pkg.sv
sv/lct_store.sv
sv/lct_ctrl.sv
sv/lru_cache_timestamp_top.sv
sv/lct_checker.sv
sim/tb_top.sv
